### rtl/conv3_pkg.sv
// ----------------------------------------------------------------------------
// conv3_pkg
// Shared types and constants of the 3x3 convolution filter.
// ----------------------------------------------------------------------------
package conv3_pkg;

  localparam int unsigned FrameRows = 128;
  localparam int unsigned FrameCols = 128;
  localparam int unsigned RowW      = $clog2(FrameRows);
  localparam int unsigned ColW      = $clog2(FrameCols);

  localparam int unsigned PixW      = 8;
  localparam int unsigned KernRowW  = 3 * PixW;
  localparam int unsigned CfgIdxW   = 2;

  typedef logic [PixW-1:0]             pix_t;
  typedef logic signed [PixW-1:0]      res_t;
  typedef logic [KernRowW-1:0]         kern_row_t;
  typedef logic [2:0][KernRowW-1:0]    kern_t;
  typedef logic [2:0][2:0][PixW-1:0]   win_t;

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CfgKernTop = 2'd0,
    CfgKernMid = 2'd1,
    CfgKernBot = 2'd2
  } cfg_idx_e;

  // one full neighbourhood handed to the multiply-accumulate unit
  typedef struct packed {
    logic last;
    win_t pix;
  } win_item_t;

endpackage

### rtl/conv3_if.sv
// ----------------------------------------------------------------------------
// conv3 stream interfaces
// Valid/ready channels for the pixel input and the filtered result output.
// ----------------------------------------------------------------------------
interface conv3_pix_if;
  conv3_pkg::pix_t pixel;
  logic            valid;
  logic            ready;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface conv3_res_if;
  conv3_pkg::res_t filtered;
  logic            frame_end;
  logic            valid;
  logic            ready;

  modport source (output valid, output filtered, output frame_end, input ready);
  modport sink   (input valid, input filtered, input frame_end, output ready);
endinterface

### rtl/conv3_ram.sv
// ----------------------------------------------------------------------------
// conv3_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module conv3_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/conv3_mac.sv
// ----------------------------------------------------------------------------
// conv3_mac
// Nine pixel-by-coefficient products, registered; byte sum, output register.
// ----------------------------------------------------------------------------
module conv3_mac (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  conv3_pkg::kern_t      kern_i,
  input  logic                  in_valid_i,
  input  conv3_pkg::win_item_t  in_item_i,
  output logic                  in_ready_o,
  conv3_res_if.source           res_o
);
  import conv3_pkg::*;

  // only the low byte of the sum is kept, so each product is kept mod 256
  logic [2:0][2:0][PixW-1:0] prod_d, prod_q;
  logic                      prod_v_q, prod_last_q;
  logic                      prod_en, out_en;
  logic [PixW-1:0]           sum;
  res_t                      out_q;
  logic                      out_v_q, out_last_q;

  assign out_en     = !out_v_q || res_o.ready;
  assign prod_en    = !prod_v_q || out_en;
  assign in_ready_o = prod_en;

  always_comb begin
    for (int kr = 0; kr < 3; kr++) begin
      for (int kc = 0; kc < 3; kc++) begin
        prod_d[kr][kc] = PixW'(in_item_i.pix[kr][kc] * kern_i[kr][PixW*kc +: PixW]);
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int kr = 0; kr < 3; kr++) begin
      for (int kc = 0; kc < 3; kc++) begin
        sum = sum + prod_q[kr][kc];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (prod_en) begin
        prod_v_q <= in_valid_i;
      end
      if (out_en) begin
        out_v_q <= prod_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_en && in_valid_i) begin
      prod_q      <= prod_d;
      prod_last_q <= in_item_i.last;
    end
    if (out_en && prod_v_q) begin
      out_q      <= res_t'(sum);
      out_last_q <= prod_last_q;
    end
  end

  assign res_o.valid     = out_v_q;
  assign res_o.filtered  = out_q;
  assign res_o.frame_end = out_last_q;

endmodule

### rtl/conv3x3_line_buffer_filter.sv
// ----------------------------------------------------------------------------
// conv3x3_line_buffer_filter
// 3x3 convolution over a raster pixel stream with two line buffers.
//
//   channel   dir  handshake          payload
//   pix_i     in   valid/ready        pixel (8 b unsigned)
//   res_o     out  valid/ready        filtered (8 b signed), frame_end
//   cfg       in   cfg_we_i           cfg_idx_i, cfg_data_i (24 b)
//
// One pixel per cycle unless res_o stalls; each result passes the window,
// product and output registers. Both line buffers share one 16-bit RAM, read
// on transfer and written from the window stage, never at the entry read.
// Reset clears positions, window and kernel; the RAM is not cleared.
// Border pixels produce no result and take no slot past the window stage.
// ----------------------------------------------------------------------------
module conv3x3_line_buffer_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [conv3_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  conv3_pkg::kern_row_t          cfg_data_i,
  conv3_pix_if.sink                     pix_i,
  conv3_res_if.source                   res_o
);
  import conv3_pkg::*;

  localparam int unsigned LineW = 2 * PixW;

  kern_t           kern_q;
  logic [RowW-1:0] row_q;
  logic [ColW-1:0] col_q;

  logic            s1_v_q, s1_int_q, s1_last_q;
  pix_t            s1_px_q;
  logic [ColW-1:0] s1_col_q;

  win_t            win_q, win_sh;
  logic [LineW-1:0] line_rd, line_wr;
  logic            s1_en, take, mac_ready;
  win_item_t       mac_item;

  // kernel registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kern_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgKernTop: kern_q[0] <= cfg_data_i;
        CfgKernMid: kern_q[1] <= cfg_data_i;
        CfgKernBot: kern_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // window stage retires when empty, border, or the mac takes it
  assign s1_en       = !s1_v_q || !s1_int_q || mac_ready;
  assign pix_i.ready = s1_en;
  assign take        = pix_i.valid && s1_en;

  // upper line in the high byte, middle line in the low byte
  assign line_wr = {line_rd[PixW-1:0], s1_px_q};

  conv3_ram #(
    .Width (LineW),
    .Depth (FrameCols)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_v_q && s1_en),
    .waddr_i (s1_col_q),
    .wdata_i (line_wr),
    .re_i    (take),
    .raddr_i (col_q),
    .rdata_o (line_rd)
  );

  always_comb begin
    win_sh = win_q;
    for (int kr = 0; kr < 3; kr++) begin
      win_sh[kr][0] = win_q[kr][1];
      win_sh[kr][1] = win_q[kr][2];
    end
    win_sh[0][2] = line_rd[LineW-1:PixW];
    win_sh[1][2] = line_rd[PixW-1:0];
    win_sh[2][2] = s1_px_q;
  end

  assign mac_item.last = s1_last_q;
  assign mac_item.pix  = win_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      s1_v_q    <= 1'b0;
      s1_int_q  <= 1'b0;
      s1_last_q <= 1'b0;
      win_q     <= '0;
    end else begin
      if (s1_en) begin
        s1_v_q <= pix_i.valid;
      end
      if (take) begin
        s1_int_q  <= (row_q >= RowW'(2)) && (col_q >= ColW'(2));
        s1_last_q <= (row_q == RowW'(FrameRows - 1)) && (col_q == ColW'(FrameCols - 1));
        if (col_q == ColW'(FrameCols - 1)) begin
          col_q <= '0;
          row_q <= (row_q == RowW'(FrameRows - 1)) ? '0 : row_q + RowW'(1);
        end else begin
          col_q <= col_q + ColW'(1);
        end
      end
      if (s1_v_q && s1_en) begin
        win_q <= win_sh;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_px_q  <= pix_i.pixel;
      s1_col_q <= col_q;
    end
  end

  conv3_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .kern_i     (kern_q),
    .in_valid_i (s1_v_q && s1_int_q),
    .in_item_i  (mac_item),
    .in_ready_o (mac_ready),
    .res_o      (res_o)
  );

endmodule

### test/tb_conv3x3_line_buffer_filter.sv
// ----------------------------------------------------------------------------
// tb_conv3x3_line_buffer_filter
// Self-checking bench for the 3x3 line buffer convolution filter. A model of
// the line buffers and the window predicts each filtered result. Pixels go in
// random bursts with random gaps, and results are taken under a random stall
// pattern. Each result transfer is checked against the oldest prediction.
// Kernels change between idle phases.
// ----------------------------------------------------------------------------
module tb_conv3x3_line_buffer_filter;
  import conv3_pkg::*;

  localparam int unsigned TotalItems  = 1350;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned MaxPrinted  = 40;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;

  typedef enum int unsigned {
    PixRandom,
    PixFlat,
    PixExtremes,
    PixDim,
    PixEdgeList
  } pix_mode_e;

  typedef struct {
    res_t filtered;
    logic frame_end;
  } filt_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  kern_row_t          cfg_data_i;

  conv3_pix_if pix_if ();
  conv3_res_if res_if ();

  conv3x3_line_buffer_filter uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_if),
    .res_o      (res_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // filter model state
  kern_row_t   kern_rows [3];
  pix_t        line_two_back [FrameCols];
  pix_t        line_one_back [FrameCols];
  pix_t        nbhd [3][3];
  int unsigned cur_row;
  int unsigned cur_col;
  filt_res_t   filtered_q [$];

  int unsigned pixels_sent  = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned burst_left   = 0;
  int unsigned gap_pct      = 0;
  bit          sink_stalls  = 1'b0;
  logic [15:0] stall_pat    = 16'hffff;
  logic [3:0]  stall_step   = '0;
  int unsigned quiet_cycles = 0;

  function automatic void convolve_pixel(input pix_t px);
    int        sum;
    filt_res_t res;
    sum = 0;
    for (int r = 0; r < 3; r++) begin
      nbhd[r][0] = nbhd[r][1];
      nbhd[r][1] = nbhd[r][2];
    end
    nbhd[0][2] = line_two_back[cur_col];
    nbhd[1][2] = line_one_back[cur_col];
    nbhd[2][2] = px;
    line_two_back[cur_col] = line_one_back[cur_col];
    line_one_back[cur_col] = px;
    // only interior centres give a result
    if (cur_row >= 2 && cur_col >= 2) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          sum += int'(nbhd[r][c]) * int'($signed(kern_rows[r][PixW*c +: PixW]));
        end
      end
      res.filtered  = res_t'(sum[7:0]);
      res.frame_end = (cur_row == FrameRows - 1) && (cur_col == FrameCols - 1);
      filtered_q.push_back(res);
    end
    cur_col++;
    if (cur_col == FrameCols) begin
      cur_col = 0;
      cur_row = (cur_row == FrameRows - 1) ? 0 : cur_row + 1;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < MaxPrinted) begin
      $display("%0t: result %0d: %s", $time, results_seen, msg);
    end
    mismatch_cnt++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    filt_res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (filtered_q.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = filtered_q.pop_front();
        if (res_if.filtered !== want.filtered) begin
          report_mismatch($sformatf("filtered %0d, expected %0d",
                                    res_if.filtered, want.filtered));
        end
        if (res_if.frame_end !== want.frame_end) begin
          report_mismatch($sformatf("frame_end %b, expected %b",
                                    res_if.frame_end, want.frame_end));
        end
      end
      results_seen++;
    end
  end

  // receiver stalls on a rotating mask that is reloaded now and then
  always @(posedge clk_i) begin
    if (!sink_stalls) begin
      res_if.ready <= 1'b1;
    end else begin
      res_if.ready <= stall_pat[stall_step];
    end
    stall_step <= stall_step + 4'd1;
    if (stall_step == 4'hf && $urandom_range(0, 3) == 0) begin
      stall_pat <= 16'($urandom) | 16'h0001;
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("conv3x3_line_buffer_filter regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic pix_t pick_pixel(input pix_mode_e mode, input pix_t flat_val,
                                      input int unsigned n);
    case (mode)
      PixFlat:     return flat_val;
      PixExtremes: return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
      PixDim:      return pix_t'($urandom_range(0, 7));
      PixEdgeList: begin
        case (n % 8)
          0:       return 8'h00;
          1:       return 8'hff;
          2:       return 8'h01;
          3:       return 8'hfe;
          4:       return 8'h7f;
          5:       return 8'h80;
          6:       return 8'h55;
          default: return 8'haa;
        endcase
      end
      default:     return pix_t'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input pix_t px);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
        pix_if.valid <= 1'b0;
        pix_if.pixel <= pix_t'($urandom);
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= px;
    do @(posedge clk_i); while (!pix_if.ready);
    convolve_pixel(px);
    burst_left--;
    pixels_sent++;
  endtask

  task automatic send_run(input int unsigned count, input pix_mode_e mode,
                          input pix_t flat_val);
    for (int unsigned n = 0; n < count; n++) begin
      send_pixel(pick_pixel(mode, flat_val, n));
    end
  endtask

  // pipeline empty: all results in, plus margin for border pixels in flight
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic config_write(input logic [CfgIdxW-1:0] idx, input kern_row_t data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CfgKernTop: kern_rows[0] = data;
      CfgKernMid: kern_rows[1] = data;
      CfgKernBot: kern_rows[2] = data;
      default:    ;
    endcase
  endtask

  task automatic load_kernel(input kern_row_t top, input kern_row_t mid,
                             input kern_row_t bot);
    config_write(CfgKernTop, top);
    config_write(CfgKernMid, mid);
    config_write(CfgKernBot, bot);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // kernel still at reset value, so every interior result is zero
  task automatic test_reset_kernel();
    gap_pct     = 0;
    sink_stalls = 1'b0;
    send_run(3 * FrameCols, PixRandom, 8'h00);
  endtask

  task automatic test_extreme_sums();
    wait_idle();
    load_kernel(24'h808080, 24'h808080, 24'h808080);
    gap_pct     = 30;
    sink_stalls = 1'b1;
    send_run(FrameCols, PixFlat, 8'hff);
    wait_idle();
    load_kernel(24'h7f7f7f, 24'h7f7f7f, 24'h7f7f7f);
    send_run(FrameCols / 2, PixFlat, 8'hff);
    send_run(FrameCols / 2, PixFlat, 8'h00);
    wait_idle();
    load_kernel(24'h7f807f, 24'h807f80, 24'h7f807f);
    send_run(FrameCols, PixExtremes, 8'h00);
    wait_idle();
    load_kernel(24'h01ff00, 24'h7f0180, 24'hff807f);
    send_run(FrameCols, PixEdgeList, 8'h00);
  endtask

  // a write to the spare index must leave the kernel alone
  task automatic test_unused_register();
    wait_idle();
    config_write(CfgIdxUnused, kern_row_t'($urandom));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    send_run(40, PixRandom, 8'h00);
  endtask

  // one coefficient at a time checks the byte order of every register
  task automatic test_coefficient_placement();
    kern_row_t rows [3];
    for (int unsigned p = 0; p < 9; p++) begin
      wait_idle();
      rows = '{default: '0};
      rows[p / 3][PixW*(p % 3) +: PixW] = pix_t'($urandom) | 8'h01;
      load_kernel(rows[0], rows[1], rows[2]);
      gap_pct     = (p % 2 == 0) ? 0 : 50;
      sink_stalls = (p % 3 == 0);
      send_run(24, PixRandom, 8'h00);
    end
  endtask

  // random phases with fresh kernels and traffic settings
  task automatic test_random_frames();
    int unsigned kind;
    int unsigned len;
    pix_mode_e   mode;
    while (pixels_sent < TotalItems) begin
      wait_idle();
      kind = $urandom_range(0, 5);
      if (kind == 0) begin
        load_kernel(24'h808080, 24'h808080, 24'h808080);
      end else if (kind == 1) begin
        load_kernel(24'h7f7f7f, 24'h7f7f7f, 24'h7f7f7f);
      end else begin
        load_kernel(kern_row_t'($urandom), kern_row_t'($urandom), kern_row_t'($urandom));
      end
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 15;
        default: gap_pct = 60;
      endcase
      sink_stalls = ($urandom_range(0, 3) != 0);
      mode = ($urandom_range(0, 9) < 7) ? PixRandom
                                        : pix_mode_e'($urandom_range(1, 4));
      len = $urandom_range(32, 96);
      if (len > TotalItems - pixels_sent) begin
        len = TotalItems - pixels_sent;
      end
      send_run(len, mode, pix_t'($urandom));
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CfgKernTop;
    cfg_data_i   = '0;
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    res_if.ready = 1'b0;
    kern_rows    = '{default: '0};
    nbhd         = '{default: '{default: '0}};
    cur_row      = 0;
    cur_col      = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_kernel();
    test_extreme_sums();
    test_unused_register();
    test_coefficient_placement();
    test_random_frames();

    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("conv3x3_line_buffer_filter regression: pass");
    end else begin
      $display("conv3x3_line_buffer_filter regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/conv3_pkg.sv
rtl/conv3_if.sv
rtl/conv3_ram.sv
rtl/conv3_mac.sv
rtl/conv3x3_line_buffer_filter.sv
test/tb_conv3x3_line_buffer_filter.sv
